FILE: design/ptw_pkg.sv
package ptw_pkg;

  localparam int AddrW  = 52;
  localparam int VaddrW = 48;
  localparam int EntryW = 64;
  localparam int KindW  = 2;
  localparam int LevelW = 3;

  localparam logic [KindW-1:0] KIND_READ  = 2'd0;
  localparam logic [KindW-1:0] KIND_DONE  = 2'd1;
  localparam logic [KindW-1:0] KIND_PROTO = 2'd2;

  localparam logic [LevelW-1:0] LVL_IDLE = 3'd0;
  localparam logic [LevelW-1:0] LVL_1    = 3'd1;
  localparam logic [LevelW-1:0] LVL_2    = 3'd2;
  localparam logic [LevelW-1:0] LVL_3    = 3'd3;
  localparam logic [LevelW-1:0] LVL_4    = 3'd4;

  localparam int PresentBit = 0;
  localparam int LargeBit   = 7;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [VaddrW-1:0] vaddr;
  } walk_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] read_addr;
    logic [AddrW-1:0] phys_addr;
    logic             fault;
  } result_t;

endpackage

FILE: design/ptw_core.sv
module ptw_core
  import ptw_pkg::*;
(
  input  logic              action,
  input  logic [VaddrW-1:0] virt_addr,
  input  logic [EntryW-1:0] entry_data,
  input  logic [AddrW-1:0]  table_base,
  input  walk_t             walk,
  output walk_t             walk_next,
  output result_t           res
);

  logic             idle;
  logic [AddrW-1:0] table_addr;
  logic [AddrW-1:0] frame_4k;
  logic [8:0]       next_index;

  assign idle       = (walk.level < LVL_1) || (walk.level > LVL_4);
  assign table_addr = {16'd0, entry_data[35:12], 12'd0};
  assign frame_4k   = table_addr;

  always_comb begin
    unique case (walk.level)
      LVL_1:   next_index = walk.vaddr[38:30];
      LVL_2:   next_index = walk.vaddr[29:21];
      default: next_index = walk.vaddr[20:12];
    endcase
  end

  always_comb begin
    walk_next = walk;
    res       = '{kind: KIND_PROTO, read_addr: '0, phys_addr: '0, fault: 1'b0};
    if (action == 1'b0) begin
      if (idle) begin
        walk_next.vaddr = virt_addr;
        walk_next.level = LVL_1;
        res.kind        = KIND_READ;
        res.read_addr   = {table_base[AddrW-1:4], 4'd0}
                          + {40'd0, virt_addr[47:39], 3'd0};
      end
    end else if (idle) begin
      walk_next.level = LVL_IDLE;
    end else if (!entry_data[PresentBit]) begin
      walk_next.level = LVL_IDLE;
      res.kind        = KIND_DONE;
      res.fault       = 1'b1;
    end else if (walk.level == LVL_2 && entry_data[LargeBit]) begin
      walk_next.level = LVL_IDLE;
      res.kind        = KIND_DONE;
      res.phys_addr   = {entry_data[51:30], walk.vaddr[29:0]};
    end else if (walk.level == LVL_3 && entry_data[LargeBit]) begin
      walk_next.level = LVL_IDLE;
      res.kind        = KIND_DONE;
      res.phys_addr   = table_addr + {31'd0, walk.vaddr[20:0]};
    end else if (walk.level == LVL_4) begin
      walk_next.level = LVL_IDLE;
      res.kind        = KIND_DONE;
      if (frame_4k == '0) begin
        res.fault = 1'b1;
      end else begin
        res.phys_addr = {frame_4k[AddrW-1:12], walk.vaddr[11:0]};
      end
    end else begin
      walk_next.level = walk.level + LevelW'(1);
      res.kind        = KIND_READ;
      res.read_addr   = table_addr + {40'd0, next_index, 3'd0};
    end
  end

endmodule

FILE: design/ptw_in_stage.sv
module ptw_in_stage
  import ptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [VaddrW-1:0] virt_addr,
  input  logic [EntryW-1:0] entry_data,
  input  logic              advance_ok,
  output logic              full,
  output logic              held_action,
  output logic [VaddrW-1:0] held_vaddr,
  output logic [EntryW-1:0] held_entry
);

  assign in_stall = full && !advance_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!in_stall) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_action <= action;
      held_vaddr  <= virt_addr;
      held_entry  <= entry_data;
    end
  end

endmodule

FILE: design/four_level_page_table_walker.sv
// Four-level page table walker for 48-bit virtual addresses.
// Input words arrive on in_valid/in_stall: action 0 starts a walk with
// virt_addr, action 1 hands back the 64-bit entry that memory returned.
// Every input word yields exactly one output word on out_valid/out_stall:
// kind 0 asks for an entry read at read_addr, kind 1 ends the walk with
// phys_addr or fault, kind 2 flags a word that came out of order.
// table_base is loaded through cfg_write/cfg_data; the user must do this
// only while the walker is idle, the block itself does not enforce it.
// Each word waits in the input register and passes through the step logic
// into the output register. One word per cycle is sustained unless the
// receiver stalls; the walk state is read and updated in the single step
// stage. When the receiver stalls, the output register keeps its word, and
// in_stall is raised while the input register is full. Synchronous reset
// empties both registers, returns the walker to idle and clears table_base.
module four_level_page_table_walker
  import ptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [AddrW-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [VaddrW-1:0] virt_addr,
  input  logic [EntryW-1:0] entry_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KindW-1:0]  kind,
  output logic [AddrW-1:0]  read_addr,
  output logic [AddrW-1:0]  phys_addr,
  output logic              fault
);

  logic [AddrW-1:0]  table_base;
  walk_t             walk;
  walk_t             walk_next;
  result_t           res;
  logic              out_free;
  logic              advance;
  logic              full;
  logic              held_action;
  logic [VaddrW-1:0] held_vaddr;
  logic [EntryW-1:0] held_entry;

  assign out_free = !out_valid || !out_stall;
  assign advance  = full && out_free;

  ptw_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .virt_addr   (virt_addr),
    .entry_data  (entry_data),
    .advance_ok  (out_free),
    .full        (full),
    .held_action (held_action),
    .held_vaddr  (held_vaddr),
    .held_entry  (held_entry)
  );

  ptw_core u_core (
    .action     (held_action),
    .virt_addr  (held_vaddr),
    .entry_data (held_entry),
    .table_base (table_base),
    .walk       (walk),
    .walk_next  (walk_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base <= '0;
    end else if (cfg_write) begin
      table_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk      <= '{level: LVL_IDLE, vaddr: '0};
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        walk <= walk_next;
      end
      if (out_free) begin
        out_valid <= full;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind      <= res.kind;
      read_addr <= res.read_addr;
      phys_addr <= res.phys_addr;
      fault     <= res.fault;
    end
  end

  a_fault_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && fault |-> kind == KIND_DONE && phys_addr == '0)
    else $error("fault reported outside a finished walk");

  a_read_keeps_busy: assert property (@(posedge clk) disable iff (rst)
    advance && res.kind == KIND_READ |=> walk.level != LVL_IDLE)
    else $error("read request issued but walker went idle");

  a_done_goes_idle: assert property (@(posedge clk) disable iff (rst)
    advance && res.kind == KIND_DONE |=> walk.level == LVL_IDLE)
    else $error("walk finished but walker still busy");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    full && !out_free |=> full && $stable(held_action) && $stable(held_entry))
    else $error("input register lost a word while blocked");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind == KIND_READ || kind == KIND_DONE || kind == KIND_PROTO)
    else $error("illegal result kind");

endmodule

FILE: tb/sv/ptw_walk_checker.sv
`timescale 1ns / 100ps

module ptw_walk_checker
  import ptw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [AddrW-1:0]  cfg_data,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              action,
  input  logic [VaddrW-1:0] virt_addr,
  input  logic [EntryW-1:0] entry_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [KindW-1:0]  kind,
  input  logic [AddrW-1:0]  read_addr,
  input  logic [AddrW-1:0]  phys_addr,
  input  logic              fault,
  output int                mismatches,
  output int                awaited
);

  localparam logic [AddrW-1:0] FrameMask = 52'h0_000F_FFFF_F000;
  localparam logic [AddrW-1:0] GigaMask  = 52'hF_FFFF_C000_0000;

  logic [AddrW-1:0]  base_q;
  logic [LevelW-1:0] level_q;
  logic [VaddrW-1:0] vaddr_q;
  result_t           awaited_words[$];

  function automatic logic [AddrW-1:0] entry_addr(logic [AddrW-1:0] tbl,
                                                  logic [LevelW-1:0] lvl,
                                                  logic [VaddrW-1:0] va);
    int         sh;
    logic [8:0] idx;
    sh  = 12 + 9 * (4 - int'(lvl));
    idx = 9'(va >> sh);
    return tbl + AddrW'({idx, 3'b000});
  endfunction

  // one word in, one word out; walk state advances as the walker does
  function automatic result_t walk_step(logic act, logic [VaddrW-1:0] va,
                                        logic [EntryW-1:0] e);
    result_t          r;
    logic [AddrW-1:0] frame;
    r     = '0;
    frame = e[AddrW-1:0] & FrameMask;
    if (act == 1'b0) begin
      if (level_q != LVL_IDLE) begin
        r.kind = KIND_PROTO;
      end else begin
        vaddr_q     = va;
        level_q     = LVL_1;
        r.kind      = KIND_READ;
        r.read_addr = entry_addr({base_q[AddrW-1:4], 4'b0000}, LVL_1, va);
      end
    end else if (level_q == LVL_IDLE) begin
      r.kind = KIND_PROTO;
    end else if (!e[PresentBit]) begin
      level_q = LVL_IDLE;
      r.kind  = KIND_DONE;
      r.fault = 1'b1;
    end else if (level_q == LVL_2 && e[LargeBit]) begin
      level_q     = LVL_IDLE;
      r.kind      = KIND_DONE;
      r.phys_addr = (e[AddrW-1:0] & GigaMask) + AddrW'(vaddr_q[29:0]);
    end else if (level_q == LVL_3 && e[LargeBit]) begin
      level_q     = LVL_IDLE;
      r.kind      = KIND_DONE;
      r.phys_addr = frame + AddrW'(vaddr_q[20:0]);
    end else if (level_q == LVL_4) begin
      level_q = LVL_IDLE;
      r.kind  = KIND_DONE;
      if (frame == '0) begin
        r.fault = 1'b1;
      end else begin
        r.phys_addr = frame + AddrW'(vaddr_q[11:0]);
      end
    end else begin
      level_q     = level_q + LevelW'(1);
      r.kind      = KIND_READ;
      r.read_addr = entry_addr(frame, level_q, vaddr_q);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      base_q  = '0;
      level_q = LVL_IDLE;
      vaddr_q = '0;
      awaited_words.delete();
    end else begin
      if (cfg_write) begin
        base_q = cfg_data;
      end
      if (in_valid && !in_stall) begin
        awaited_words.push_back(walk_step(action, virt_addr, entry_data));
      end
      if (out_valid && !out_stall) begin
        got = '{kind, read_addr, phys_addr, fault};
        if (awaited_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got kind %0d read %h phys %h fault %0d",
                   $time, got.kind, got.read_addr, got.phys_addr, got.fault);
        end else begin
          want = awaited_words.pop_front();
          if (got.kind != want.kind) begin
            mismatches++;
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, got.kind);
          end
          if (got.read_addr != want.read_addr) begin
            mismatches++;
            $display("%0t: read_addr expected %h, got %h", $time, want.read_addr,
                     got.read_addr);
          end
          if (got.phys_addr != want.phys_addr) begin
            mismatches++;
            $display("%0t: phys_addr expected %h, got %h", $time, want.phys_addr,
                     got.phys_addr);
          end
          if (got.fault != want.fault) begin
            mismatches++;
            $display("%0t: fault expected %0d, got %0d", $time, want.fault, got.fault);
          end
        end
      end
    end
    awaited <= awaited_words.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ptw_pkg::*;

  localparam logic [EntryW-1:0] AllOnes = '1;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [AddrW-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic              action;
  logic [VaddrW-1:0] virt_addr;
  logic [EntryW-1:0] entry_data;
  logic              out_valid;
  logic              out_stall;
  logic [KindW-1:0]  kind;
  logic [AddrW-1:0]  read_addr;
  logic [AddrW-1:0]  phys_addr;
  logic              fault;
  int                mismatches;
  int                awaited;

  int sent;
  bit quiet;

  four_level_page_table_walker i_dut (.*);

  ptw_walk_checker i_checker (.*);

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [EntryW-1:0] rand_entry();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VaddrW-1:0] rand_vaddr();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[VaddrW-1:0];
  endfunction

  task automatic send_word(logic act, logic [VaddrW-1:0] va, logic [EntryW-1:0] e);
    int n;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    virt_addr  <= va;
    entry_data <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_base(logic [AddrW-1:0] v);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // start, then one entry per level until the walk ends, with a stray start now and then
  task automatic run_walk();
    logic [EntryW-1:0] e;
    int                lvl;
    bit                done;
    done = 1'b0;
    send_word(1'b0, rand_vaddr(), rand_entry());
    for (lvl = 1; lvl <= 4 && !done; lvl++) begin
      if ($urandom_range(0, 19) == 0) begin
        send_word(1'b0, rand_vaddr(), rand_entry());
      end
      e = rand_entry();
      e[PresentBit] = ($urandom_range(0, 11) != 0);
      if (lvl == 2 || lvl == 3) begin
        e[LargeBit] = ($urandom_range(0, 3) == 0);
      end
      if (lvl == 4 && $urandom_range(0, 7) == 0) begin
        e[35:12] = '0;
      end
      send_word(1'b1, rand_vaddr(), e);
      done = !e[PresentBit] || ((lvl == 2 || lvl == 3) && e[LargeBit]);
    end
  endtask

  initial begin
    out_stall <= 1'b0;
    forever begin
      int n;
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[four_level_page_table_walker] ERROR");
    $finish;
  end

  initial begin
    logic [AddrW-1:0] base;
    int               ph;
    int               target;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    action     <= 1'b0;
    virt_addr  <= '0;
    entry_data <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_base('1);

    // entry while idle, start during a walk, 1 GB page
    send_word(1'b1, '0, '0);
    send_word(1'b0, '1, '0);
    send_word(1'b0, '0, '0);
    send_word(1'b1, '0, AllOnes);
    send_word(1'b1, '0, AllOnes);
    // full walk ending on a zero frame
    send_word(1'b0, '0, '0);
    repeat (4) send_word(1'b1, '0, 64'h1);
    // not present
    send_word(1'b0, '1, '0);
    send_word(1'b1, '0, AllOnes & ~64'h1);
    // 2 MB page, offset sum carries into the frame
    send_word(1'b0, '1, '0);
    send_word(1'b1, '0, AllOnes);
    send_word(1'b1, '0, AllOnes & ~64'h80);
    send_word(1'b1, '0, AllOnes);
    // 4 KB page
    send_word(1'b0, '1, '0);
    repeat (3) send_word(1'b1, '0, AllOnes & ~64'h80);
    send_word(1'b1, '0, AllOnes);

    for (ph = 0; ph < 5; ph++) begin
      unique case (ph)
        0: base = '0;
        1: base = '1;
        3: base = AddrW'({$urandom, $urandom}) | 52'hF;
        default: base = AddrW'({$urandom, $urandom});
      endcase
      wait_drained();
      quiet = (ph == 4);
      write_base(base);
      target = 21 + 200 * (ph + 1);
      while (sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(1'b1, rand_vaddr(), rand_entry());
        end
        run_walk();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[four_level_page_table_walker] OK");
    end else begin
      $display("[four_level_page_table_walker] ERROR");
    end
    $finish;
  end

endmodule
